/* sv/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // push source select
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_LENH = 2'd2;
  localparam logic [1:0] SRC_LENL = 2'd3;

  typedef struct packed {
    logic       push;       // write one word into the block buffer
    logic [1:0] push_src;
    logic       pad_full;   // pad word is 0x80000000 (else zero)
    logic       add_bytes;  // add byte count of accepted word
    logic       start;      // load working vars from hash
    logic       round;      // run one round
    logic       finish;     // fold working vars into hash
    logic       emit_load;  // capture digest into output shifter
    logic       emit_shift; // advance output shifter
    logic       restart;    // back to initial values
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;  // push into the last slot; the fill slot wraps to zero
    logic [3:0] fill_slot;
    logic       round_last;
  } sha_sts_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
    32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
    32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
    32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
    32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

endpackage

/* sv/sha_ctrl.sv */
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sha_pkg::sha_sts_t sts_i,
  output sha_pkg::sha_cmd_t cmd_o
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_PRUN  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_RFIN  = 3'd6;
  localparam logic [2:0] ST_PFIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pad_first_q, pad_first_d;
  logic       pad_full_q, pad_full_d;
  logic       round_run_q, round_run_d;
  logic       len_hi_q, len_hi_d;
  logic [2:0] emit_cnt_q, emit_cnt_d;
  logic       acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign acc         = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    pad_first_d = pad_first_q;
    pad_full_d  = pad_full_q;
    round_run_d = round_run_q;
    len_hi_d    = len_hi_q;
    emit_cnt_d  = emit_cnt_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.add_bytes = 1'b1;
          if (!in_word_i.last_item || in_word_i.byte_count >= 3'd4) begin
            cmd_o.push     = 1'b1;
            cmd_o.push_src = SRC_DATA;
            if (in_word_i.last_item) begin
              pad_first_d = 1'b1;
              pad_full_d  = 1'b1;
            end
            if (sts_i.block_full) begin
              cmd_o.start = 1'b1;
              round_run_d = in_word_i.last_item;
              state_d     = ST_RUN;
            end else if (in_word_i.last_item) begin
              state_d = ST_PAD;
            end
          end else begin
            // short last word: masked data plus pad byte is pushed in pad state
            pad_first_d = 1'b1;
            pad_full_d  = 1'b0;
            state_d     = ST_PAD;
          end
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = ST_RFIN;
      end
      ST_RFIN: begin
        cmd_o.finish = 1'b1;
        state_d      = round_run_q ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        cmd_o.push     = 1'b1;
        cmd_o.pad_full = pad_full_q;
        pad_first_d    = 1'b0;
        if (pad_first_q) cmd_o.push_src = SRC_PAD;
        else if (sts_i.fill_slot == 4'd14) begin
          cmd_o.push_src = SRC_LENH;
          len_hi_d       = 1'b1;
        end
        else if (sts_i.fill_slot == 4'd15 && len_hi_q) cmd_o.push_src = SRC_LENL;
        else cmd_o.push_src = SRC_PAD;
        if (!pad_first_q) cmd_o.pad_full = 1'b0;
        if (sts_i.block_full) begin
          cmd_o.start = 1'b1;
          round_run_d = !len_hi_q;
          len_hi_d    = 1'b0;
          state_d     = ST_PRUN;
        end
      end
      ST_PRUN: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = ST_PFIN;
      end
      ST_PFIN: begin
        cmd_o.finish = 1'b1;
        state_d      = round_run_q ? ST_PAD : ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.emit_load = 1'b1;
        emit_cnt_d      = 3'd0;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          cmd_o.emit_shift = 1'b1;
          emit_cnt_d       = emit_cnt_q + 3'd1;
          if (emit_cnt_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pad_first_q <= 1'b0;
      pad_full_q  <= 1'b0;
      round_run_q <= 1'b0;
      len_hi_q    <= 1'b0;
      emit_cnt_q  <= 3'd0;
    end else begin
      state_q     <= state_d;
      pad_first_q <= pad_first_d;
      pad_full_q  <= pad_full_d;
      round_run_q <= round_run_d;
      len_hi_q    <= len_hi_d;
      emit_cnt_q  <= emit_cnt_d;
    end
  end

endmodule

/* sv/sha_dp.sv */
`timescale 1ns / 1ps
module sha_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::in_word_t in_word_i,
  input  sha_pkg::sha_cmd_t cmd_i,
  output sha_pkg::sha_sts_t sts_o,
  output logic [31:0]       digest_o,
  output logic [2:0]        index_o
);
  import sha_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] out_q [8];
  logic [3:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [60:0] bytes_q;
  logic [2:0]  idx_q;
  logic [31:0] push_w, wcur, t1, t2, s0, s1, w15, w2, keep, padw;
  logic [2:0]  n;
  logic [63:0] bits;
  logic [60:0] add_n;

  // clamp byte count, full words always count four
  always_comb begin
    n = (in_word_i.byte_count > 3'd4) ? 3'd4 : in_word_i.byte_count;
    if (!in_word_i.last_item) n = 3'd4;
    add_n = {58'd0, n};
    case (n)
      3'd0:    keep = 32'h0;
      3'd1:    keep = 32'hff000000;
      3'd2:    keep = 32'hffff0000;
      3'd3:    keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    padw = (in_word_i.data_word & keep) | (32'h80000000 >> {n, 3'b000});
    bits = {bytes_q, 3'b000};
    case (cmd_i.push_src)
      SRC_DATA: push_w = in_word_i.data_word;
      SRC_PAD:  push_w = cmd_i.pad_full ? 32'h80000000 : 32'h0;
      SRC_LENH: push_w = bits[63:32];
      default:  push_w = bits[31:0];
    endcase
  end

  // short last word: the held input supplies the masked first pad word
  logic [31:0] pad_hold_q;
  logic        short_q;
  logic [31:0] push_final;
  assign push_final = (cmd_i.push_src == SRC_PAD && short_q) ? pad_hold_q : push_w;

  always_comb begin
    w15  = w_q[rnd_q[3:0] + 4'd1];
    w2   = w_q[rnd_q[3:0] + 4'd14];
    s0   = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
    s1   = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
    wcur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]]
         : w_q[rnd_q[3:0]] + s0 + w_q[rnd_q[3:0] + 4'd9] + s1;
    t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wcur;
    t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign sts_o.fill_slot  = fill_q;
  assign sts_o.block_full = cmd_i.push && (fill_q == 4'd15);
  assign sts_o.round_last = (rnd_q == 6'd63);
  assign digest_o         = out_q[0];
  assign index_o          = idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) w_q[fill_q] <= push_final;
    else if (cmd_i.round) w_q[rnd_q[3:0]] <= wcur;
    if (cmd_i.add_bytes) begin
      pad_hold_q <= padw;
      short_q    <= in_word_i.last_item && (n != 3'd4);
    end else if (cmd_i.push) begin
      short_q <= 1'b0;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
    if (cmd_i.emit_load) begin
      for (int i = 0; i < 8; i++) out_q[i] <= h_q[i];
    end else if (cmd_i.emit_shift) begin
      for (int i = 0; i < 7; i++) out_q[i] <= out_q[i + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      fill_q  <= 4'd0;
      rnd_q   <= 6'd0;
      bytes_q <= 61'd0;
      idx_q   <= 3'd0;
    end else begin
      if (cmd_i.push) fill_q <= fill_q + 4'd1;
      if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.add_bytes) bytes_q <= bytes_q + add_n;
      if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.emit_load) idx_q <= 3'd0;
      else if (cmd_i.emit_shift) idx_q <= idx_q + 3'd1;
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
        bytes_q <= 61'd0;
        fill_q  <= 4'd0;
      end
    end
  end

endmodule

/* sv/sha256_stream_hasher_top.sv */
`timescale 1ns / 1ps
// a word that completes a block starts 64 rounds through the single shared round unit,
// then a fold into the hash; input stalls meanwhile. a last word adds one push per padding
// slot, 64 rounds and a fold for each of one or two final blocks, a load of the digest
// and the eight digest words, during all of which input also stalls.
// reset: asynchronous, active low; hash returns to the initial values, counts clear
module sha256_stream_hasher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sha_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sha_pkg::out_word_t out_word_o
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [31:0] digest;
  logic [2:0]  index;

  // sequencer: gathers words, pads and runs rounds
  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // block buffer, round unit and hash state
  sha_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .digest_o  (digest),
    .index_o   (index)
  );

  assign out_word_o.digest_word = digest;
  assign out_word_o.word_index  = index;
  assign out_word_o.last_word   = (index == 3'd7);

`ifndef SYNTH
  // never accept input while digest words are out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("input open while emitting");
  // a round never coincides with a buffer push
  a_round_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.round && cmd.push)) else $error("round and push together");
  // after the final digest word the block is free again
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_word_o.last_word) |=> !out_valid_o)
    else $error("emit did not end");
`endif

endmodule

/* tb/sv/sha256_stream_hasher_top_tb.sv */
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;
  import sha_pkg::*;

  localparam logic [31:0] PAD_WORD = 32'h80000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  sha256_stream_hasher_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // own copy of the hashing state
  logic [31:0] chain_h [8];
  logic [31:0] msg_blk [16];
  int unsigned blk_slot;
  logic [60:0] msg_bytes;

  in_word_t  pending_words [$];
  out_word_t digest_q [$];
  int        err_cnt;
  int        idle_pct;
  int        stall_pct;
  bit        in_taken;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // one 64-round compression over msg_blk, folded into chain_h
  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] w, w15, w2, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = msg_blk[r];
      end else begin
        w15 = msg_blk[(r - 15) & 15];
        w2  = msg_blk[(r - 2) & 15];
        w = msg_blk[r & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
          + msg_blk[(r - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        msg_blk[r & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endtask

  task automatic append_word(input logic [31:0] w);
    msg_blk[blk_slot] = w;
    blk_slot = (blk_slot + 1) & 15;
    if (blk_slot == 0) compress_block();
  endtask

  // predict the digest words caused by one accepted word
  task automatic hash_word(input in_word_t iw);
    int unsigned n;
    logic [31:0] keep;
    logic [63:0] bits;
    out_word_t   ow;
    n = (iw.byte_count > 4) ? 4 : iw.byte_count;
    if (!iw.last_item) begin
      msg_bytes += 61'd4;
      append_word(iw.data_word);
    end else begin
      msg_bytes += 61'(n);
      if (n == 4) begin
        append_word(iw.data_word);
        append_word(PAD_WORD);
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
        append_word((iw.data_word & keep) | (32'h80 << (24 - 8 * n)));
      end
      while (blk_slot != 14) append_word(32'h0);
      bits = {msg_bytes, 3'b000};
      append_word(bits[63:32]);
      append_word(bits[31:0]);
      for (int i = 0; i < 8; i++) begin
        ow.digest_word = chain_h[i];
        ow.word_index  = 3'(i);
        ow.last_word   = (i == 7);
        digest_q.push_back(ow);
      end
      for (int i = 0; i < 8; i++) chain_h[i] = INIT_H[i];
      msg_bytes = '0;
      blk_slot  = 0;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver: words change on the falling edge, held while stalled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: words accepted at the rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o && rst_ni;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) hash_word(in_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest word with none expected: %h", out_word_o);
          err_cnt++;
        end else begin
          automatic out_word_t exp_w = digest_q.pop_front();
          if (out_word_o.digest_word !== exp_w.digest_word) begin
            $error("digest_word expected %h got %h", exp_w.digest_word,
                   out_word_o.digest_word);
            err_cnt++;
          end
          if (out_word_o.word_index !== exp_w.word_index) begin
            $error("word_index expected %0d got %0d", exp_w.word_index,
                   out_word_o.word_index);
            err_cnt++;
          end
          if (out_word_o.last_word !== exp_w.last_word) begin
            $error("last_word expected %0d got %0d", exp_w.last_word,
                   out_word_o.last_word);
            err_cnt++;
          end
        end
      end
    end
  end

  function automatic in_word_t mk_word(input logic [31:0] d, input logic [2:0] n,
                                       input logic lst);
    in_word_t w;
    w.data_word  = d;
    w.byte_count = n;
    w.last_item  = lst;
    return w;
  endfunction

  // queue one message: body words then a last word
  task automatic queue_message(input int body_len, input logic [2:0] last_n);
    for (int i = 0; i < body_len; i++)
      pending_words.push_back(mk_word($urandom, 3'($urandom_range(7)), 1'b0));
    pending_words.push_back(mk_word($urandom, last_n, 1'b1));
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || digest_q.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int words_left;
    int body_len;
    err_cnt     = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    in_word_i   = '0;
    for (int i = 0; i < 8; i++) chain_h[i] = INIT_H[i];
    for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    blk_slot  = 0;
    msg_bytes = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty message, each short last word, extreme data
    pending_words.push_back(mk_word(32'hffffffff, 3'd0, 1'b1));
    pending_words.push_back(mk_word(32'h61626300, 3'd3, 1'b1));
    pending_words.push_back(mk_word(32'hffffffff, 3'd1, 1'b1));
    pending_words.push_back(mk_word(32'hffffffff, 3'd2, 1'b1));
    pending_words.push_back(mk_word(32'h00000000, 3'd4, 1'b1));
    pending_words.push_back(mk_word(32'hffffffff, 3'd7, 1'b1));
    // short non-last word taken whole, count above four
    pending_words.push_back(mk_word(32'h12345678, 3'd1, 1'b0));
    pending_words.push_back(mk_word(32'hdeadbeef, 3'd5, 1'b1));
    // 14 words: padding and length spill into a second block
    queue_message(13, 3'd4);
    wait_drained();

    // random messages in phases of input idling and output stalls
    words_left = 148;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      while (words_left > (3 - ph) * 37) begin
        body_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
        queue_message(body_len, 3'($urandom_range(7)));
        words_left -= body_len + 1;
      end
      wait_drained();
    end
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
